[rtl/lpht_pkg.sv]
// package: sizes, types and codes shared by the hash table modules
`default_nettype none
package lpht_pkg;

  localparam int LOG2_CAPACITY = 10;
  localparam int MAX_KEY_WORDS = 4;
  localparam int CAPACITY      = 1 << LOG2_CAPACITY;
  localparam int WORD_W        = 64;
  localparam int KWU_W         = 3;
  localparam int FILL_W        = 11;
  localparam int CNT_W         = LOG2_CAPACITY + 1;
  localparam int CMP_W         = (CNT_W > FILL_W) ? CNT_W : FILL_W;
  localparam int SIDX_W        = 10;

  typedef logic [LOG2_CAPACITY-1:0]              slot_t;
  typedef logic [CNT_W-1:0]                      count_t;
  typedef logic [WORD_W-1:0]                     word_t;
  typedef logic [MAX_KEY_WORDS-1:0][WORD_W-1:0]  key_t;

  typedef struct packed {
    word_t hash;
    key_t  key;
    word_t value;
  } entry_t;

  typedef struct packed {
    logic used_we;
    logic used_wdata;
    logic entry_we;
    logic value_we;
  } mem_ctrl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

  localparam logic REG_KEY_WORDS_USED = 1'b0;
  localparam logic REG_MAX_FILL       = 1'b1;

  localparam logic REQ_FIND = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  localparam logic [1:0] STATUS_NOT_FOUND = 2'd0;
  localparam logic [1:0] STATUS_FOUND     = 2'd1;
  localparam logic [1:0] STATUS_INSERTED  = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

endpackage
`default_nettype wire

[rtl/lpht_mem.sv]
// slot storage: used flags, stored hash, key words and value, registered read
`default_nettype none
module lpht_mem
  import lpht_pkg::*;
(
  input  wire logic      clk,
  input  wire slot_t     addr,
  input  wire mem_ctrl_t ctrl,
  input  wire word_t     wr_hash,
  input  wire key_t      wr_key,
  input  wire word_t     wr_value,
  output logic           rd_used,
  output entry_t         rd_entry
);

  logic  used_mem  [CAPACITY];
  word_t hash_mem  [CAPACITY];
  key_t  key_mem   [CAPACITY];
  word_t value_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (ctrl.used_we) begin
      used_mem[addr] <= ctrl.used_wdata;
    end
    rd_used <= used_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.entry_we) begin
      hash_mem[addr] <= wr_hash;
      key_mem[addr]  <= wr_key;
    end
    if (ctrl.entry_we || ctrl.value_we) begin
      value_mem[addr] <= wr_value;
    end
    rd_entry.hash  <= hash_mem[addr];
    rd_entry.key   <= key_mem[addr];
    rd_entry.value <= value_mem[addr];
  end

endmodule
`default_nettype wire

[rtl/linear_probe_hash_table.sv]
// top level: linear probing hash table with probe sequencer and result register
// each probed slot takes a read state and then a compare state; the result is registered from the done state
// one request at a time: input is taken only in the idle state, so a new request waits for the last result
// the registered read port of the slot memory sets the read and compare probe step
// after reset a clearing pass marks all slots unused, no input taken
// reset also sets key_words_used to 1, max_fill to 512 and the entry count to 0
`default_nettype none
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic              cfg_index,
  input  wire logic [FILL_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              req_type,
  input  wire logic [63:0]       key_word0,
  input  wire logic [63:0]       key_word1,
  input  wire logic [63:0]       key_word2,
  input  wire logic [63:0]       key_word3,
  input  wire logic [63:0]       key_hash,
  input  wire logic [63:0]       new_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             status,
  output logic [63:0]            value_out,
  output logic [SIDX_W-1:0]      slot_index
);

  state_t              state;
  state_t              state_next;
  logic [KWU_W-1:0]    key_words_used;
  logic [FILL_W-1:0]   max_fill;
  count_t              entry_count;
  slot_t               pos;
  count_t              probes;
  logic                req_set;
  key_t                req_key;
  word_t               req_hash;
  word_t               req_value;
  logic                hit;
  logic                empty;

  logic                rd_used;
  entry_t              rd_entry;
  mem_ctrl_t           mem_ctrl;
  key_t                wr_key;

  logic [3:0][63:0]    in_key;
  logic [KWU_W-1:0]    words_n;
  logic [MAX_KEY_WORDS-1:0] word_mask;
  logic                match;
  logic                last_probe;
  logic                out_free;
  logic                insert_ok;
  logic [1:0]          res_status;

  assign in_key = {key_word3, key_word2, key_word1, key_word0};

  always_comb begin
    if (key_words_used == '0) begin
      words_n = KWU_W'(1);
    end else if (key_words_used > KWU_W'(MAX_KEY_WORDS)) begin
      words_n = KWU_W'(MAX_KEY_WORDS);
    end else begin
      words_n = key_words_used;
    end
  end

  always_comb begin
    match = (rd_entry.hash == req_hash);
    for (int w = 0; w < MAX_KEY_WORDS; w++) begin
      word_mask[w] = (KWU_W'(w) < words_n);
      wr_key[w]    = word_mask[w] ? req_key[w] : '0;
      if (word_mask[w] && (rd_entry.key[w] != req_key[w])) begin
        match = 1'b0;
      end
    end
  end

  assign last_probe = (probes == count_t'(CAPACITY - 1));
  assign out_free   = !out_valid || !out_stall;
  assign insert_ok  = req_set && !hit && empty && (entry_count < count_t'(CAPACITY)) &&
                      (CMP_W'(entry_count) < CMP_W'(max_fill));

  always_comb begin
    if (req_set == REQ_FIND) begin
      res_status = hit ? STATUS_FOUND : STATUS_NOT_FOUND;
    end else if (hit) begin
      res_status = STATUS_FOUND;
    end else if (insert_ok) begin
      res_status = STATUS_INSERTED;
    end else begin
      res_status = STATUS_FULL;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (pos == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (!rd_used || match || last_probe) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall = 1'b1;
    mem_ctrl = '0;
    case (state)
      ST_CLEAR: begin
        mem_ctrl.used_we = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_DONE: begin
        if (out_free) begin
          mem_ctrl.used_we    = insert_ok;
          mem_ctrl.used_wdata = 1'b1;
          mem_ctrl.entry_we   = insert_ok;
          mem_ctrl.value_we   = req_set && hit;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      pos            <= '0;
      key_words_used <= KWU_W'(1);
      max_fill       <= FILL_W'(512);
      entry_count    <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_KEY_WORDS_USED: key_words_used <= cfg_data[KWU_W-1:0];
          REG_MAX_FILL:       max_fill       <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state)
        ST_CLEAR: begin
          pos <= pos + slot_t'(1);
        end
        ST_IDLE: begin
          if (in_valid) begin
            pos <= key_hash[LOG2_CAPACITY-1:0];
          end
        end
        ST_CMP: begin
          if (rd_used && !match && !last_probe) begin
            pos <= pos + slot_t'(1);
          end
        end
        ST_DONE: begin
          if (out_free && insert_ok) begin
            entry_count <= entry_count + count_t'(1);
          end
        end
        default: begin
        end
      endcase
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request, probe and result payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req_set   <= req_type;
      req_hash  <= key_hash;
      req_value <= new_value;
      probes    <= '0;
      for (int w = 0; w < MAX_KEY_WORDS; w++) begin
        req_key[w] <= in_key[w];
      end
    end
    if (state == ST_CMP) begin
      hit   <= rd_used && match;
      empty <= !rd_used;
      probes <= probes + count_t'(1);
    end
    if (state == ST_DONE && out_free) begin
      status     <= res_status;
      value_out  <= (req_set == REQ_FIND && hit) ? rd_entry.value : '0;
      slot_index <= (hit || insert_ok) ? SIDX_W'(pos) : '0;
    end
  end

  lpht_mem u_mem (
    .clk      (clk),
    .addr     (pos),
    .ctrl     (mem_ctrl),
    .wr_hash  (req_hash),
    .wr_key   (wr_key),
    .wr_value (req_value),
    .rd_used  (rd_used),
    .rd_entry (rd_entry)
  );

endmodule
`default_nettype wire

[test/linear_probe_hash_table_check.sv]
// checker: predicts every hash table answer from the transfers seen and compares results
module linear_probe_hash_table_check
  import lpht_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [FILL_W-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              req_type,
  input  word_t             key_word0,
  input  word_t             key_word1,
  input  word_t             key_word2,
  input  word_t             key_word3,
  input  word_t             key_hash,
  input  word_t             new_value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        status,
  input  word_t             value_out,
  input  logic [SIDX_W-1:0] slot_index,
  output int                pending,
  output int                errors
);

  localparam int ANSWER_DEPTH = 16;

  typedef struct packed {
    logic [1:0]        status;
    word_t             value;
    logic [SIDX_W-1:0] slot;
  } answer_t;

  answer_t           answer_buf[ANSWER_DEPTH];
  int                rd_ptr;
  int                wr_ptr;
  bit                slot_used[CAPACITY];
  word_t             slot_hash[CAPACITY];
  key_t              slot_key[CAPACITY];
  word_t             slot_value[CAPACITY];
  int                stored_count;
  logic [KWU_W-1:0]  words_reg;
  logic [FILL_W-1:0] fill_limit;

  function automatic answer_t lookup_or_store(logic kind, key_t key, word_t hash, word_t value);
    answer_t answer;
    slot_t   pos;
    int      n;
    int      probes;
    int      w;
    bit      hit;
    bit      empty;
    bit      same;
    answer = '0;
    n = (words_reg == 0) ? 1 : (words_reg > MAX_KEY_WORDS) ? MAX_KEY_WORDS : int'(words_reg);
    pos = hash[LOG2_CAPACITY-1:0];
    hit = 1'b0;
    empty = 1'b0;
    for (probes = 0; probes < CAPACITY && !hit && !empty; probes++) begin
      if (!slot_used[pos]) begin
        empty = 1'b1;
      end else begin
        same = (slot_hash[pos] == hash);
        for (w = 0; w < n; w++)
          if (slot_key[pos][w] != key[w]) same = 1'b0;
        if (same) hit = 1'b1;
        else pos = pos + 1'b1;
      end
    end
    if (kind == REQ_FIND) begin
      if (hit) begin
        answer.status = STATUS_FOUND;
        answer.value = slot_value[pos];
        answer.slot = SIDX_W'(pos);
      end else begin
        answer.status = STATUS_NOT_FOUND;
      end
    end else if (hit) begin
      slot_value[pos] = value;
      answer.status = STATUS_FOUND;
      answer.slot = SIDX_W'(pos);
    end else if (!empty || stored_count >= CAPACITY || stored_count + 1 > int'(fill_limit)) begin
      answer.status = STATUS_FULL;
    end else begin
      slot_used[pos] = 1'b1;
      slot_hash[pos] = hash;
      for (w = 0; w < MAX_KEY_WORDS; w++)
        slot_key[pos][w] = (w < n) ? key[w] : '0;
      slot_value[pos] = value;
      stored_count = stored_count + 1;
      answer.status = STATUS_INSERTED;
      answer.slot = SIDX_W'(pos);
    end
    return answer;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      stored_count = 0;
      words_reg = KWU_W'(1);
      fill_limit = FILL_W'(512);
      rd_ptr = 0;
      wr_ptr = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (wr_ptr == rd_ptr) begin
          errors = errors + 1;
          $error("result transfer with no request waiting");
        end else begin
          want = answer_buf[rd_ptr % ANSWER_DEPTH];
          rd_ptr = rd_ptr + 1;
          if (status != want.status) begin
            errors = errors + 1;
            $error("status expected %0d actual %0d", want.status, status);
          end
          if (value_out != want.value) begin
            errors = errors + 1;
            $error("value_out expected %h actual %h", want.value, value_out);
          end
          if (slot_index != want.slot) begin
            errors = errors + 1;
            $error("slot_index expected %0d actual %0d", want.slot, slot_index);
          end
        end
      end
      if (cfg_write) begin
        if (cfg_index == REG_KEY_WORDS_USED) words_reg = cfg_data[KWU_W-1:0];
        else fill_limit = cfg_data;
      end
      if (in_valid && !in_stall) begin
        answer_buf[wr_ptr % ANSWER_DEPTH] = lookup_or_store(req_type,
          {key_word3, key_word2, key_word1, key_word0}, key_hash, new_value);
        wr_ptr = wr_ptr + 1;
      end
    end
    pending <= wr_ptr - rd_ptr;
  end

endmodule

[test/linear_probe_hash_table_test.sv]
// testbench top: drives requests and register writes into the hash table and gives the verdict
module linear_probe_hash_table_test;
  import lpht_pkg::*;

  localparam int STALL_LIMIT = 25000;
  localparam int POOL_DEPTH  = 4096;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic              cfg_index = REG_KEY_WORDS_USED;
  logic [FILL_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              req_type = REQ_FIND;
  word_t             key_word0 = '0;
  word_t             key_word1 = '0;
  word_t             key_word2 = '0;
  word_t             key_word3 = '0;
  word_t             key_hash = '0;
  word_t             new_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  word_t             value_out;
  logic [SIDX_W-1:0] slot_index;
  int                pending;
  int                errors;

  int    send_idle_pct = 0;
  int    stall_pct = 0;
  int    idle_cycles = 0;
  slot_t cluster_base = '0;
  key_t  pool_key[POOL_DEPTH];
  word_t pool_hash[POOL_DEPTH];
  int    pool_size = 0;

  linear_probe_hash_table uut (.*);

  linear_probe_hash_table_check check (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic transfer_request(input logic kind, input word_t w0, input word_t w1,
                                  input word_t w2, input word_t w3, input word_t hash,
                                  input word_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    key_word0 <= w0;
    key_word1 <= w1;
    key_word2 <= w2;
    key_word3 <= w3;
    key_hash <= hash;
    new_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [FILL_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int words, input int fill);
    settle();
    // upper bits of the key word count write carry noise
    write_reg(REG_KEY_WORDS_USED,
              (FILL_W'($urandom) & ~FILL_W'(7)) | FILL_W'(words));
    write_reg(REG_MAX_FILL, FILL_W'(fill));
  endtask

  task automatic random_request(input int insert_pct);
    int    r;
    int    i;
    int    t;
    logic  kind;
    key_t  k;
    word_t h;
    r = $urandom_range(99);
    if (pool_size == 0 || r < insert_pct) begin
      kind = REQ_SET;
      k = {rand_word(), rand_word(), rand_word(), rand_word()};
      if ($urandom_range(3) == 0)
        for (i = $urandom_range(1, 3); i < MAX_KEY_WORDS; i++) k[i] = '0;
      h = rand_word();
      if ($urandom_range(4) == 0) h[LOG2_CAPACITY-1:0] = cluster_base + slot_t'($urandom_range(15));
      if ($urandom_range(49) == 0) h = '1;
      if (pool_size != 0 && $urandom_range(9) == 0) h = pool_hash[$urandom_range(pool_size - 1)];
      i = (pool_size < POOL_DEPTH) ? pool_size : $urandom_range(POOL_DEPTH - 1);
      pool_key[i] = k;
      pool_hash[i] = h;
      if (pool_size < POOL_DEPTH) pool_size++;
    end else if (r < insert_pct + (100 - insert_pct) * 9 / 10) begin
      i = $urandom_range(pool_size - 1);
      k = pool_key[i];
      h = pool_hash[i];
      t = $urandom_range(19);
      if (t < 3) begin
        for (i = $urandom_range(1, 3); i < MAX_KEY_WORDS; i++) k[i] = '0;
      end else if (t < 6) begin
        k[$urandom_range(MAX_KEY_WORDS - 1)] = rand_word();
      end
      kind = $urandom_range(1) ? REQ_SET : REQ_FIND;
    end else begin
      kind = REQ_FIND;
      k = {rand_word(), rand_word(), rand_word(), rand_word()};
      h = rand_word();
    end
    transfer_request(kind, k[0], k[1], k[2], k[3], h, rand_word());
  endtask

  task automatic run_phase(input int words, input int fill, input int items,
                           input int send_pct, input int recv_pct, input int insert_pct);
    configure(words, fill);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    cluster_base = slot_t'($urandom_range(CAPACITY - 1));
    repeat (items) random_request(insert_pct);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty table, wraparound at the top slot, updates, probing past other hashes
    transfer_request(REQ_FIND, '0, '0, '0, '0, '0, rand_word());
    transfer_request(REQ_SET, '0, '0, '0, '0, '0, '1);
    transfer_request(REQ_FIND, '0, '1, '1, '1, '0, '0);
    transfer_request(REQ_SET, '1, '1, '1, '1, '1, '0);
    transfer_request(REQ_SET, 64'd1, '0, '0, '0, '1, rand_word());
    transfer_request(REQ_FIND, 64'd1, rand_word(), rand_word(), rand_word(), '1, '0);
    transfer_request(REQ_SET, '0, '0, '0, '0, '0, 64'd5);
    transfer_request(REQ_FIND, '0, '0, '0, '0, '0, '1);
    transfer_request(REQ_FIND, '0, '0, '0, '0, 64'h400, '0);
    transfer_request(REQ_FIND, 64'd2, '0, '0, '0, 64'd3, rand_word());

    // no room allowed: inserts refused, updates still land
    configure(1, 0);
    transfer_request(REQ_SET, 64'd7, '0, '0, '0, 64'd7, rand_word());
    transfer_request(REQ_SET, '0, '0, '0, '0, '0, 64'd9);

    configure(1, 4);
    transfer_request(REQ_SET, 64'd8, '0, '0, '0, 64'd8, rand_word());
    transfer_request(REQ_SET, 64'd9, '0, '0, '0, 64'd9, rand_word());

    // word count above range, stored extra words compare as zero
    configure(7, 4);
    transfer_request(REQ_FIND, '0, '0, '0, '0, '0, '0);
    transfer_request(REQ_FIND, '0, 64'd1, '0, '0, '0, '0);
    transfer_request(REQ_SET, '0, '0, '0, '1, '0, rand_word());

    // word count of zero acts as one
    configure(0, 1);
    transfer_request(REQ_SET, 64'd3, '1, '0, '0, 64'd3, rand_word());
    transfer_request(REQ_FIND, 64'd8, rand_word(), rand_word(), rand_word(), 64'd8, '0);

    run_phase(1, 200, 300, 0, 0, 40);
    run_phase(3, 400, 300, 79, 0, 40);
    run_phase(4, 600, 300, 0, 79, 40);
    run_phase(6, 800, 300, 24, 24, 40);
    run_phase(0, 1024, 330, 0, 0, 60);
    run_phase(2, 2047, 200, 0, 79, 95);
    run_phase(4, 2047, 200, 24, 24, 95);

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
